### sv/rrts_pkg.sv
// Package for the round-robin task scheduler with mutexes.
// Holds field widths, event, status and slot-state codes, and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package rrts_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int TASK_SLOTS_DEF  = 16;
  localparam int MUTEX_COUNT_DEF = 4;

  // Fixed field widths of the word on each channel.
  localparam int MODE_W   = 3;
  localparam int TASK_W   = 4;
  localparam int MUTEX_W  = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;

  // Event codes.
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOCK    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRYLOCK = 3'd4;
  localparam logic [MODE_W-1:0] MODE_UNLOCK  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_JOIN    = 3'd6;
  localparam logic [MODE_W-1:0] MODE_NONE    = 3'd7;

  // Status codes reported with each result word.
  localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_OWNER   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_MAIN_EXIT   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NO_RUNNABLE = 3'd4;

  // Task slot states.
  localparam logic [SLOT_W-1:0] SLOT_UNUSED  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_READY   = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_RUNNING = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_BLOCKED = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_ZOMBIE  = 3'd4;

  // Commands from the controller to the datapath; at most one per cycle.
  typedef struct packed {
    logic capture;   // latch the input word and clear the result fields
    logic exec;      // apply the event to the scheduler state
    logic scan;      // examine one slot of the round-robin search
    logic load_out;  // move the result into the output register
  } rrts_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic search_req;  // the event just applied needs a search
    logic scan_end;    // the slot examined ends the search
  } rrts_sts_t;

endpackage

`default_nettype wire

### sv/rrts_ctrl.sv
// Controller state machine of the task scheduler.
// Sequences capture, execute, slot scan and result load; uses rrts_pkg.
`default_nettype none

module rrts_ctrl import rrts_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  input  rrts_sts_t  sts_i,
  output rrts_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next-state and command decode.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.search_req ? S_SCAN : S_RESULT;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### sv/rrts_dp.sv
// Datapath of the task scheduler: slot states, mutex tables, search
// pointer and the output register. Driven by rrts_ctrl; uses rrts_pkg.
`default_nettype none

module rrts_dp import rrts_pkg::*; #(
  parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
  parameter int MUTEX_COUNT = MUTEX_COUNT_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  rrts_cmd_t           cmd_i,
  output rrts_sts_t           sts_o,
  input  wire  [MODE_W-1:0]   mode_i,
  input  wire  [TASK_W-1:0]   target_task_i,
  input  wire  [MUTEX_W-1:0]  mutex_index_i,
  output logic [TASK_W-1:0]   running_task_o,
  output logic [TASK_W-1:0]   previous_task_o,
  output logic                switched_o,
  output logic                granted_o,
  output logic [TASK_W-1:0]   created_task_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int SW  = $clog2(TASK_SLOTS);
  localparam int NFW = $clog2(TASK_SLOTS + 1);
  localparam int MW  = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;

  localparam logic [SW-1:0]  LastSlot  = SW'(TASK_SLOTS - 1);
  localparam logic [NFW-1:0] SlotLimit = NFW'(TASK_SLOTS);

  // Scheduler state.
  logic [SLOT_W-1:0]     slot_state_q [TASK_SLOTS];
  logic [SLOT_W-1:0]     slot_state_d [TASK_SLOTS];
  logic [SW-1:0]         current_q, current_d;
  logic [NFW-1:0]        next_free_q, next_free_d;
  logic                  lock_held_q [MUTEX_COUNT];
  logic                  lock_held_d [MUTEX_COUNT];
  logic [SW-1:0]         lock_owner_q [MUTEX_COUNT];
  logic [SW-1:0]         lock_owner_d [MUTEX_COUNT];
  logic [TASK_SLOTS-1:0] lock_waiters_q [MUTEX_COUNT];
  logic [TASK_SLOTS-1:0] lock_waiters_d [MUTEX_COUNT];

  // Event in progress.
  logic [MODE_W-1:0]   mode_q;
  logic [TASK_W-1:0]   target_q;
  logic [MUTEX_W-1:0]  mutex_q;
  logic [SW-1:0]       prev_q, prev_d;
  logic                granted_q, granted_d;
  logic [SW-1:0]       created_q, created_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SW-1:0]       ptr_q, ptr_d;
  logic [SW-1:0]       cnt_q, cnt_d;

  // Output register.
  logic [TASK_W-1:0]   running_task_q, previous_task_q, created_task_q;
  logic                switched_q, granted_out_q;
  logic [STATUS_W-1:0] status_out_q;

  // Decode helpers.
  logic [MODE_W-1:0] eff_mode;
  logic [SW-1:0]     cur_next;
  logic [SW-1:0]     ptr_next;
  logic [SW-1:0]     tgt_idx;
  logic              tgt_ok;
  logic [MW-1:0]     mi;
  logic              mi_ok;
  logic [SW-1:0]     nf_idx;
  logic [MW-1:0]     wait_m;
  logic              wait_any;
  logic              found;

  assign cur_next = (current_q == LastSlot) ? '0 : current_q + 1'b1;
  assign ptr_next = (ptr_q == LastSlot) ? '0 : ptr_q + 1'b1;
  assign tgt_idx  = SW'(target_q);
  assign tgt_ok   = int'(target_q) < TASK_SLOTS;
  assign mi       = MW'(mutex_q);
  assign mi_ok    = int'(mutex_q) < MUTEX_COUNT;
  assign nf_idx   = next_free_q[SW-1:0];

  // A current slot that is not running turns exit through join into a
  // tick; a mutex beyond the table makes a mutex event a no-op.
  always_comb begin
    eff_mode = mode_q;
    if ((mode_q inside {[MODE_EXIT:MODE_JOIN]}) &&
        (slot_state_q[current_q] != SLOT_RUNNING)) begin
      eff_mode = MODE_TICK;
    end else if ((mode_q inside {[MODE_LOCK:MODE_UNLOCK]}) && !mi_ok) begin
      eff_mode = MODE_NONE;
    end
  end

  // Lowest mutex that the scanned slot waits on.
  always_comb begin
    wait_m   = '0;
    wait_any = 1'b0;
    for (int m = MUTEX_COUNT - 1; m >= 0; m--) begin
      if (lock_waiters_q[m][ptr_q]) begin
        wait_m   = MW'(m);
        wait_any = 1'b1;
      end
    end
  end

  // Event execution and one search step per cycle.
  always_comb begin
    slot_state_d   = slot_state_q;
    current_d      = current_q;
    next_free_d    = next_free_q;
    lock_held_d    = lock_held_q;
    lock_owner_d   = lock_owner_q;
    lock_waiters_d = lock_waiters_q;
    prev_d         = prev_q;
    granted_d      = granted_q;
    created_d      = created_q;
    status_d       = status_q;
    ptr_d          = ptr_q;
    cnt_d          = cnt_q;
    sts_o          = '0;
    found          = 1'b0;

    if (cmd_i.capture) begin
      prev_d    = current_q;
      granted_d = 1'b0;
      created_d = '0;
      status_d  = STATUS_OK;
    end else if (cmd_i.exec) begin
      ptr_d = cur_next;
      cnt_d = '0;
      case (eff_mode)
        MODE_TICK: begin
          sts_o.search_req = 1'b1;
        end
        MODE_CREATE: begin
          if (next_free_q >= SlotLimit) begin
            status_d = STATUS_NO_FREE;
          end else begin
            created_d              = nf_idx;
            slot_state_d[nf_idx]   = SLOT_READY;
            next_free_d            = next_free_q + 1'b1;
            sts_o.search_req       = 1'b1;
          end
        end
        MODE_EXIT: begin
          if (current_q == '0) begin
            status_d = STATUS_MAIN_EXIT;
          end else begin
            slot_state_d[current_q] = SLOT_ZOMBIE;
            ptr_d                   = '0;
            sts_o.search_req        = 1'b1;
          end
        end
        MODE_LOCK: begin
          if (!lock_held_q[mi]) begin
            lock_held_d[mi]  = 1'b1;
            lock_owner_d[mi] = current_q;
            granted_d        = 1'b1;
          end else begin
            lock_waiters_d[mi][current_q] = 1'b1;
            slot_state_d[current_q]       = SLOT_BLOCKED;
            sts_o.search_req              = 1'b1;
          end
        end
        MODE_TRYLOCK: begin
          if (!lock_held_q[mi]) begin
            lock_held_d[mi]  = 1'b1;
            lock_owner_d[mi] = current_q;
            granted_d        = 1'b1;
          end
        end
        MODE_UNLOCK: begin
          if (lock_held_q[mi] && (lock_owner_q[mi] == current_q)) begin
            lock_held_d[mi] = 1'b0;
            // Every blocked or ready waiter becomes ready; it retries later.
            for (int s = 0; s < TASK_SLOTS; s++) begin
              if (lock_waiters_q[mi][s] &&
                  ((slot_state_q[s] == SLOT_BLOCKED) ||
                   (slot_state_q[s] == SLOT_READY))) begin
                slot_state_d[s] = SLOT_READY;
              end
            end
          end else begin
            status_d = STATUS_NOT_OWNER;
          end
        end
        MODE_JOIN: begin
          if (tgt_ok && (slot_state_q[tgt_idx] == SLOT_ZOMBIE)) begin
            granted_d = 1'b1;
          end else begin
            sts_o.search_req = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.scan) begin
      // A ready waiter takes its mutex if free, else it blocks again.
      if (slot_state_q[ptr_q] == SLOT_RUNNING) begin
        found = 1'b1;
      end else if (slot_state_q[ptr_q] == SLOT_READY) begin
        if (!wait_any) begin
          found = 1'b1;
        end else if (!lock_held_q[wait_m]) begin
          lock_held_d[wait_m]           = 1'b1;
          lock_owner_d[wait_m]          = ptr_q;
          lock_waiters_d[wait_m][ptr_q] = 1'b0;
          found                         = 1'b1;
        end else begin
          slot_state_d[ptr_q] = SLOT_BLOCKED;
        end
      end
      // Switch over: the old running slot becomes ready, the found one runs.
      if (found) begin
        if (slot_state_q[current_q] == SLOT_RUNNING) begin
          slot_state_d[current_q] = SLOT_READY;
        end
        slot_state_d[ptr_q] = SLOT_RUNNING;
        current_d           = ptr_q;
      end else if (cnt_q == LastSlot) begin
        status_d = STATUS_NO_RUNNABLE;
      end
      sts_o.scan_end = found || (cnt_q == LastSlot);
      ptr_d          = ptr_next;
      cnt_d          = cnt_q + 1'b1;
    end
  end

  // Scheduler state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TASK_SLOTS; s++) begin
        slot_state_q[s] <= (s == 0) ? SLOT_RUNNING : SLOT_UNUSED;
      end
      for (int m = 0; m < MUTEX_COUNT; m++) begin
        lock_held_q[m]    <= 1'b0;
        lock_owner_q[m]   <= '0;
        lock_waiters_q[m] <= '0;
      end
      current_q   <= '0;
      next_free_q <= NFW'(1);
    end else begin
      slot_state_q   <= slot_state_d;
      lock_held_q    <= lock_held_d;
      lock_owner_q   <= lock_owner_d;
      lock_waiters_q <= lock_waiters_d;
      current_q      <= current_d;
      next_free_q    <= next_free_d;
    end
  end

  // Event and search working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= mode_i;
      target_q <= target_task_i;
      mutex_q  <= mutex_index_i;
    end
    prev_q    <= prev_d;
    granted_q <= granted_d;
    created_q <= created_d;
    status_q  <= status_d;
    ptr_q     <= ptr_d;
    cnt_q     <= cnt_d;
  end

  // Output register, loaded once the result word is complete.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      running_task_q  <= TASK_W'(current_q);
      previous_task_q <= TASK_W'(prev_q);
      switched_q      <= (current_q != prev_q);
      granted_out_q   <= granted_q;
      created_task_q  <= TASK_W'(created_q);
      status_out_q    <= status_q;
    end
  end

  assign running_task_o  = running_task_q;
  assign previous_task_o = previous_task_q;
  assign switched_o      = switched_q;
  assign granted_o       = granted_out_q;
  assign created_task_o  = created_task_q;
  assign status_o        = status_out_q;

endmodule

`default_nettype wire

### sv/round_robin_task_scheduler_mutex_unit.sv
// Top level of the round-robin task scheduler with mutexes.
// Joins rrts_ctrl and rrts_dp; uses rrts_pkg.
`default_nettype none

// A hardware thread scheduler: one event word in (tick, create, exit, lock,
// trylock, unlock, join), one result word out giving the running slot, the
// previous slot, whether a switch took place, grant, created slot and a
// status code. Events are handled one at a time. An event that does not
// reschedule is captured, executed and loaded into the output register;
// an event that reschedules also runs the round-robin search in between,
// which examines up to TASK_SLOTS slots, one slot per cycle. The result
// sits in an output register, so the next word is accepted in the cycle
// after the result is loaded, even while the result still waits for the
// consumer. There is no clearing pass after reset: the block is ready in
// the first cycle.
module round_robin_task_scheduler_mutex_unit import rrts_pkg::*; #(
  parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
  parameter int MUTEX_COUNT = MUTEX_COUNT_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [MODE_W-1:0]   mode_i,
  input  wire  [TASK_W-1:0]   target_task_i,
  input  wire  [MUTEX_W-1:0]  mutex_index_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [TASK_W-1:0]   running_task_o,
  output logic [TASK_W-1:0]   previous_task_o,
  output logic                switched_o,
  output logic                granted_o,
  output logic [TASK_W-1:0]   created_task_o,
  output logic [STATUS_W-1:0] status_o
);

  rrts_cmd_t cmd;
  rrts_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rrts_dp #(
    .TASK_SLOTS  (TASK_SLOTS),
    .MUTEX_COUNT (MUTEX_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .target_task_i   (target_task_i),
    .mutex_index_i   (mutex_index_i),
    .running_task_o  (running_task_o),
    .previous_task_o (previous_task_o),
    .switched_o      (switched_o),
    .granted_o       (granted_o),
    .created_task_o  (created_task_o),
    .status_o        (status_o)
  );

  // An accepted word is executed in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd.exec)
    else $error("accepted word was not executed");

  // The controller issues at most one command per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.exec, cmd.scan, cmd.load_out}))
    else $error("more than one datapath command");

  // A switch only comes from a successful search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && switched_o) |-> (status_o == STATUS_OK))
    else $error("switch reported with a failure status");

  // A grant never comes with a switch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_o) |-> !switched_o)
    else $error("grant reported together with a switch");

endmodule

`default_nettype wire

### sim/rrts_dispatch_checker.sv
// Checker for the round-robin task scheduler: predicts each result word from
// the accepted event words and compares it with what the block returns.
// Depends on rrts_pkg for field widths, codes and default sizes.
`timescale 1ns / 1ps
`default_nettype none

module rrts_dispatch_checker import rrts_pkg::*; (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // Event channel, observed only.
  input  wire                        in_valid_i,
  input  wire                        in_ready_i,
  input  wire  [MODE_W-1:0]          mode_i,
  input  wire  [TASK_W-1:0]          target_task_i,
  input  wire  [MUTEX_W-1:0]         mutex_index_i,
  // Result channel, observed only.
  input  wire                        out_valid_i,
  input  wire                        out_ready_i,
  input  wire  [TASK_W-1:0]          running_task_i,
  input  wire  [TASK_W-1:0]          previous_task_i,
  input  wire                        switched_i,
  input  wire                        granted_i,
  input  wire  [TASK_W-1:0]          created_task_i,
  input  wire  [STATUS_W-1:0]        status_i,
  // Verdict and a view of the predicted scheduler state for the stimulus.
  output int                         fail_count_o,
  output int                         pending_o,
  output logic [TASK_W-1:0]          cur_slot_o,
  output logic                       cur_running_o,
  output logic [MUTEX_COUNT_DEF-1:0] held_mask_o,
  output logic [MUTEX_COUNT_DEF-1:0] owned_mask_o
);

  localparam int SLOTS      = TASK_SLOTS_DEF;
  localparam int MUTEXES    = MUTEX_COUNT_DEF;

  typedef struct packed {
    logic [TASK_W-1:0]   running;
    logic [TASK_W-1:0]   previous;
    logic                switched;
    logic                granted;
    logic [TASK_W-1:0]   created;
    logic [STATUS_W-1:0] status;
  } dispatch_t;

  // Predicted scheduler state.
  logic [SLOT_W-1:0] task_state [SLOTS];
  int unsigned       cur_task;
  int unsigned       free_task;
  logic              mtx_held [MUTEXES];
  int unsigned       mtx_owner [MUTEXES];
  logic [SLOTS-1:0]  mtx_waiters [MUTEXES];

  dispatch_t predicted_dispatch_q [$];

  initial fail_count_o = 0;

  // Round-robin search from slot first. A ready slot that waits on a mutex
  // retries it here: it takes a free mutex, or blocks again and the search
  // moves on. Returns -1 when no slot can run.
  function automatic int pick_next_task(input int unsigned first);
    int unsigned s;
    int m;
    for (int i = 0; i < SLOTS; i++) begin
      s = (first + i) % SLOTS;
      if (task_state[s] == SLOT_RUNNING) return s;
      if (task_state[s] == SLOT_READY) begin
        m = -1;
        for (int k = MUTEXES - 1; k >= 0; k--) begin
          if (mtx_waiters[k][s]) m = k;
        end
        if (m < 0) return s;
        if (!mtx_held[m]) begin
          mtx_held[m]       = 1'b1;
          mtx_owner[m]      = s;
          mtx_waiters[m][s] = 1'b0;
          return s;
        end
        task_state[s] = SLOT_BLOCKED;
      end
    end
    return -1;
  endfunction

  // Context switch to the slot found by the search; the current slot keeps
  // its state when nothing can run.
  function automatic logic [STATUS_W-1:0] switch_from(input int unsigned first);
    int found;
    found = pick_next_task(first);
    if (found < 0) return STATUS_NO_RUNNABLE;
    if (task_state[cur_task] == SLOT_RUNNING) task_state[cur_task] = SLOT_READY;
    task_state[found] = SLOT_RUNNING;
    cur_task = found;
    return STATUS_OK;
  endfunction

  // Applies one event word to the predicted state and returns the result word.
  function automatic dispatch_t dispatch_event(input logic [MODE_W-1:0] mode,
                                               input logic [TASK_W-1:0] target,
                                               input logic [MUTEX_W-1:0] mi);
    logic [MODE_W-1:0] op;
    int unsigned prev;
    int unsigned after;
    dispatch_t r;
    r     = '0;
    prev  = cur_task;
    after = (prev + 1) % SLOTS;
    op    = mode;
    // With the current slot not running, exit through join behave as a tick.
    if (op >= MODE_EXIT && op <= MODE_JOIN && task_state[prev] != SLOT_RUNNING)
      op = MODE_TICK;
    if (op >= MODE_LOCK && op <= MODE_UNLOCK && int'(mi) >= MUTEXES) op = MODE_NONE;
    case (op)
      MODE_TICK: begin
        r.status = switch_from(after);
      end
      MODE_CREATE: begin
        if (free_task >= SLOTS) begin
          r.status = STATUS_NO_FREE;
        end else begin
          r.created             = free_task[TASK_W-1:0];
          task_state[free_task] = SLOT_READY;
          free_task++;
          r.status = switch_from(after);
        end
      end
      MODE_EXIT: begin
        if (prev == 0) begin
          r.status = STATUS_MAIN_EXIT;
        end else begin
          task_state[prev] = SLOT_ZOMBIE;
          r.status = switch_from(0);
        end
      end
      MODE_LOCK: begin
        if (!mtx_held[mi]) begin
          mtx_held[mi]  = 1'b1;
          mtx_owner[mi] = prev;
          r.granted     = 1'b1;
        end else begin
          // Blocks even when the current slot owns the mutex.
          mtx_waiters[mi][prev] = 1'b1;
          task_state[prev]      = SLOT_BLOCKED;
          r.status = switch_from(after);
        end
      end
      MODE_TRYLOCK: begin
        if (!mtx_held[mi]) begin
          mtx_held[mi]  = 1'b1;
          mtx_owner[mi] = prev;
          r.granted     = 1'b1;
        end
      end
      MODE_UNLOCK: begin
        if (mtx_held[mi] && mtx_owner[mi] == prev) begin
          // Waiters wake up but keep their waiter bits until they win the mutex.
          mtx_held[mi] = 1'b0;
          for (int s = 0; s < SLOTS; s++) begin
            if (mtx_waiters[mi][s] &&
                (task_state[s] == SLOT_BLOCKED || task_state[s] == SLOT_READY))
              task_state[s] = SLOT_READY;
          end
        end else begin
          r.status = STATUS_NOT_OWNER;
        end
      end
      MODE_JOIN: begin
        if (task_state[target] == SLOT_ZOMBIE) r.granted = 1'b1;
        else r.status = switch_from(after);
      end
      default: ;
    endcase
    r.running  = cur_task[TASK_W-1:0];
    r.previous = prev[TASK_W-1:0];
    r.switched = (cur_task != prev);
    return r;
  endfunction

  // Exposes the state that the next event word will see.
  function automatic void publish_view();
    cur_slot_o    = cur_task[TASK_W-1:0];
    cur_running_o = (task_state[cur_task] == SLOT_RUNNING);
    for (int m = 0; m < MUTEXES; m++) begin
      held_mask_o[m]  = mtx_held[m];
      owned_mask_o[m] = mtx_held[m] && (mtx_owner[m] == cur_task);
    end
  endfunction

  // Text of one result word for the mismatch report.
  function automatic string word_text(input dispatch_t w);
    return $sformatf("run=%0d prev=%0d sw=%0b gr=%0b new=%0d st=%0d",
                     w.running, w.previous, w.switched, w.granted,
                     w.created, w.status);
  endfunction

  // Results are checked before the new event is predicted; a result can never
  // belong to a word accepted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    dispatch_t got;
    dispatch_t want;
    string bad;
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) task_state[s] = SLOT_UNUSED;
      task_state[0] = SLOT_RUNNING;
      cur_task      = 0;
      free_task     = 1;
      for (int m = 0; m < MUTEXES; m++) begin
        mtx_held[m]    = 1'b0;
        mtx_owner[m]   = 0;
        mtx_waiters[m] = '0;
      end
      predicted_dispatch_q.delete();
      pending_o = 0;
      publish_view();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {running_task_i, previous_task_i, switched_i, granted_i,
               created_task_i, status_i};
        if (predicted_dispatch_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result word with none expected: run=%0d prev=%0d sw=%0b",
                   $time, got.running, got.previous, got.switched);
        end else begin
          want = predicted_dispatch_q.pop_front();
          bad  = "";
          if (got.running  !== want.running)  bad = {bad, " running_task"};
          if (got.previous !== want.previous) bad = {bad, " previous_task"};
          if (got.switched !== want.switched) bad = {bad, " switched"};
          if (got.granted  !== want.granted)  bad = {bad, " granted"};
          if (got.created  !== want.created)  bad = {bad, " created_task"};
          if (got.status   !== want.status)   bad = {bad, " status"};
          if (bad != "") begin
            fail_count_o++;
            $display("%0t: mismatch in%s: expected %s, actual %s",
                     $time, bad, word_text(want), word_text(got));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_dispatch_q.push_back(dispatch_event(mode_i, target_task_i,
                                                      mutex_index_i));
        publish_view();
      end
      pending_o = predicted_dispatch_q.size();
    end
  end

endmodule

`default_nettype wire

### sim/tb_round_robin_task_scheduler_mutex_unit.sv
// Top of the scheduler testbench: clock, reset, event stimulus, result
// back-pressure and the verdict. Depends on rrts_pkg, the scheduler top level
// and rrts_dispatch_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_round_robin_task_scheduler_mutex_unit;
  import rrts_pkg::*;

  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_EVENTS = 325;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic [MODE_W-1:0]    mode_i        = MODE_TICK;
  logic [TASK_W-1:0]    target_task_i = '0;
  logic [MUTEX_W-1:0]   mutex_index_i = '0;
  logic                 out_ready_i   = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [TASK_W-1:0]    running_task_o;
  logic [TASK_W-1:0]    previous_task_o;
  logic                 switched_o;
  logic                 granted_o;
  logic [TASK_W-1:0]    created_task_o;
  logic [STATUS_W-1:0]  status_o;

  int                         fail_count;
  int                         pending;
  logic [TASK_W-1:0]          sched_slot;
  logic                       sched_running;
  logic [MUTEX_COUNT_DEF-1:0] held_mask;
  logic [MUTEX_COUNT_DEF-1:0] owned_mask;

  // Idle rates in percent, and long result hold-offs asked for and served.
  int gap_pct       = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_done    = 0;

  round_robin_task_scheduler_mutex_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .target_task_i  (target_task_i),
    .mutex_index_i  (mutex_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .running_task_o (running_task_o),
    .previous_task_o(previous_task_o),
    .switched_o     (switched_o),
    .granted_o      (granted_o),
    .created_task_o (created_task_o),
    .status_o       (status_o)
  );

  rrts_dispatch_checker dispatch_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .mode_i         (mode_i),
    .target_task_i  (target_task_i),
    .mutex_index_i  (mutex_index_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .running_task_i (running_task_o),
    .previous_task_i(previous_task_o),
    .switched_i     (switched_o),
    .granted_i      (granted_o),
    .created_task_i (created_task_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .cur_slot_o     (sched_slot),
    .cur_running_o  (sched_running),
    .held_mask_o    (held_mask),
    .owned_mask_o   (owned_mask)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  always begin
    @(negedge clk_i);
    if (holds_done != hold_requests) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      holds_done++;
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Offers one event word after a random gap and returns at the falling edge
  // after it was taken.
  task automatic send_event(input logic [MODE_W-1:0]  op,
                            input logic [TASK_W-1:0]  tgt,
                            input logic [MUTEX_W-1:0] mx);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= op;
    target_task_i <= tgt;
    mutex_index_i <= mx;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Random events, mostly well-formed: locks are taken in ascending mutex
  // order so that tasks never wait on each other in a cycle, owners unlock
  // what they hold, and a task exits only when it holds nothing. A small
  // share is unconstrained noise.
  task automatic run_phase(input int count, input int gap, input int stall);
    logic [MODE_W-1:0]  op;
    logic [TASK_W-1:0]  tgt;
    logic [MUTEX_W-1:0] mx;
    logic [MUTEX_W-1:0] owned_pick;
    int pick;
    int top_owned;
    gap_pct   = gap;
    stall_pct = stall;
    repeat (count) begin
      pick      = $urandom_range(99);
      tgt       = TASK_W'($urandom_range(TASK_SLOTS_DEF - 1));
      mx        = MUTEX_W'($urandom_range(MUTEX_COUNT_DEF - 1));
      top_owned = -1;
      for (int k = 0; k < MUTEX_COUNT_DEF; k++) begin
        if (owned_mask[k]) top_owned = k;
      end
      owned_pick = mx;
      if (owned_mask != '0) begin
        do owned_pick = MUTEX_W'($urandom_range(MUTEX_COUNT_DEF - 1));
        while (!owned_mask[owned_pick]);
      end
      if (pick < 6) begin
        op = MODE_W'($urandom_range(MODE_NONE));
      end else if (pick < 28) begin
        op = MODE_TICK;
      end else if (pick < 40) begin
        op = MODE_CREATE;
      end else if (pick < 42) begin
        op = MODE_EXIT;
        if (owned_mask != '0) begin
          op = MODE_UNLOCK;
          mx = owned_pick;
        end
      end else if (pick < 61) begin
        if (top_owned == MUTEX_COUNT_DEF - 1) begin
          op = MODE_UNLOCK;
          mx = owned_pick;
        end else begin
          op = MODE_LOCK;
          mx = MUTEX_W'($urandom_range(MUTEX_COUNT_DEF - 1, top_owned + 1));
        end
      end else if (pick < 70) begin
        op = MODE_TRYLOCK;
      end else if (pick < 87) begin
        op = MODE_UNLOCK;
        if (owned_mask != '0 && $urandom_range(9) != 0) mx = owned_pick;
      end else begin
        op = MODE_JOIN;
      end
      send_event(op, tgt, mx);
    end
    wait_drained();
  endtask

  initial begin
    logic [MODE_W-1:0] tail_ops [8] = '{MODE_EXIT, MODE_LOCK, MODE_TRYLOCK, MODE_UNLOCK,
                                        MODE_JOIN, MODE_TICK, MODE_NONE, MODE_CREATE};
    logic [MUTEX_W-1:0] mx;
    int guard;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening: field extremes, every event, failing unlock and main
    // exit, an ignored word, the woken waiter that takes its mutex and the one
    // that blocks again.
    send_event(MODE_UNLOCK,  4'd0,  2'd0);  // nothing held: not owner
    send_event(MODE_EXIT,    4'd15, 2'd3);  // main task cannot exit
    send_event(MODE_NONE,    4'd15, 2'd3);  // unknown event, ignored
    send_event(MODE_TRYLOCK, 4'd0,  2'd3);
    send_event(MODE_TRYLOCK, 4'd0,  2'd3);  // already held: no grant
    send_event(MODE_LOCK,    4'd0,  2'd0);
    send_event(MODE_JOIN,    4'd0,  2'd0);  // target is alive: only a tick
    send_event(MODE_CREATE,  4'd0,  2'd0);  // task 1 starts running
    send_event(MODE_LOCK,    4'd0,  2'd0);  // task 1 blocks on mutex 0
    send_event(MODE_TICK,    4'd0,  2'd0);
    send_event(MODE_UNLOCK,  4'd0,  2'd0);  // task 1 wakes up
    send_event(MODE_CREATE,  4'd0,  2'd0);  // task 1 retries and wins mutex 0
    send_event(MODE_UNLOCK,  4'd0,  2'd3);  // owned by the main task
    send_event(MODE_UNLOCK,  4'd0,  2'd0);
    send_event(MODE_EXIT,    4'd0,  2'd0);  // task 1 becomes zombie
    send_event(MODE_JOIN,    4'd1,  2'd0);  // zombie target: granted
    send_event(MODE_JOIN,    4'd15, 2'd0);  // unused target: switch to task 2
    send_event(MODE_LOCK,    4'd15, 2'd3);  // task 2 waits on mutex 3
    send_event(MODE_LOCK,    4'd0,  2'd0);
    send_event(MODE_CREATE,  4'd0,  2'd0);  // task 3 runs
    send_event(MODE_LOCK,    4'd0,  2'd3);  // task 3 waits on mutex 3 too
    send_event(MODE_UNLOCK,  4'd0,  2'd3);  // both waiters wake up
    send_event(MODE_TICK,    4'd0,  2'd0);  // task 2 wins mutex 3
    send_event(MODE_TICK,    4'd0,  2'd0);  // task 3 loses and blocks again
    send_event(MODE_TICK,    4'd0,  2'd0);
    wait_drained();

    // The result side holds off while events keep coming, so the block backs up.
    hold_requests++;
    run_phase(PHASE_EVENTS, 0, 0);
    run_phase(PHASE_EVENTS, 79, 0);
    run_phase(PHASE_EVENTS, 0, 79);
    run_phase(PHASE_EVENTS, 21, 21);

    // The all-blocked case comes last since the tasks involved stay stuck for
    // good: every running task locks a held mutex until nothing can run.
    guard = 0;
    while (sched_running && guard < 4 * TASK_SLOTS_DEF) begin
      if (held_mask != '0) begin
        do mx = MUTEX_W'($urandom_range(MUTEX_COUNT_DEF - 1)); while (!held_mask[mx]);
        send_event(MODE_LOCK, TASK_W'($urandom_range(TASK_SLOTS_DEF - 1)), mx);
      end else begin
        send_event(MODE_TRYLOCK, TASK_W'($urandom_range(TASK_SLOTS_DEF - 1)),
                   MUTEX_W'($urandom_range(MUTEX_COUNT_DEF - 1)));
      end
      guard++;
    end
    // With no task running, exit through join act as a tick.
    foreach (tail_ops[i])
      send_event(tail_ops[i], TASK_W'($urandom_range(TASK_SLOTS_DEF - 1)),
                 MUTEX_W'($urandom_range(MUTEX_COUNT_DEF - 1)));
    wait_drained();

    // Let any stray result word show up before the verdict.
    stall_pct = 0;
    repeat (TASK_SLOTS_DEF + 8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far above the slowest correct run.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
